// ===== design/vcfh_pkg.sv =====
// Shared types, constants and command codes of the control frame handler.
package vcfh_pkg;

  // Frame geometry.
  localparam int FRAME_LENGTH = 15;
  localparam int IDX_W        = 4;
  localparam int CSUM_POS     = FRAME_LENGTH - 1;
  localparam int PAD_POS      = FRAME_LENGTH;
  localparam int LAST_DATA    = FRAME_LENGTH - 2;

  // Job queue between parser and emitter.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] HDR_BYTE = 8'h0F;

  // Command and argument codes.
  localparam logic [7:0] CMD_FREQ    = 8'h46;  // F
  localparam logic [7:0] CMD_POWER   = 8'h50;  // P
  localparam logic [7:0] CMD_PIT     = 8'h49;  // I
  localparam logic [7:0] CMD_REBOOT  = 8'h52;  // R
  localparam logic [7:0] CMD_RANGE   = 8'h72;  // r
  localparam logic [7:0] CMD_VERSION = 8'h76;  // v
  localparam logic [7:0] CMD_STATUS  = 8'h73;  // s
  localparam logic [7:0] ARG_S       = 8'h53;
  localparam logic [7:0] ARG_T       = 8'h54;

  // Result status codes.
  localparam logic [1:0] ST_LISTEN  = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Reply kinds carried by a job.
  localparam logic [1:0] RPL_NONE    = 2'd0;
  localparam logic [1:0] RPL_RANGE   = 2'd1;
  localparam logic [1:0] RPL_VERSION = 2'd2;
  localparam logic [1:0] RPL_STATUS  = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_CAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RACE_POWER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_MIN_FREQ     = 16'd5645;
  localparam logic [15:0] RST_MAX_FREQ     = 16'd5945;
  localparam logic [15:0] RST_POWER_CAP    = 16'd400;
  localparam logic [15:0] RST_RACE_POWER   = 16'd0;
  localparam logic [15:0] RST_TIMEOUT      = 16'd300;
  localparam logic [15:0] RST_INIT_TIMEOUT = 16'd1500;

  // Configuration values seen by the datapath.
  typedef struct packed {
    logic [15:0] min_frequency;
    logic [15:0] max_frequency;
    logic [15:0] power_cap;
    logic [15:0] race_power;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // One classified item, handed from parser to emitter.
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [15:0] frequency;
    logic [15:0] power;
    logic        pit_mode;
    logic        reboot;
    logic [15:0] temperature;
  } job_t;

endpackage

// ===== design/vcfh_channels.sv =====
// Request and response channel interfaces of the control frame handler.
interface vcfh_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  rx_byte;
  logic [15:0] temperature;

  modport source (output valid, req_type, rx_byte, temperature, input ready);
  modport sink   (input valid, req_type, rx_byte, temperature, output ready);
endinterface

interface vcfh_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] frequency_out;
  logic [15:0] power_setting;
  logic        pit_mode_out;
  logic [15:0] drive_power;
  logic        reboot_request;

  modport source (output valid, status, tx_valid, tx_byte, last, frequency_out,
                  power_setting, pit_mode_out, drive_power, reboot_request,
                  input ready);
  modport sink   (input valid, status, tx_valid, tx_byte, last, frequency_out,
                  power_setting, pit_mode_out, drive_power, reboot_request,
                  output ready);
endinterface

// ===== design/vcfh_front.sv =====
// Frame parser: accepts bytes and ticks, tracks frame state, issues jobs.
module vcfh_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 req_type,
  input  logic [7:0]           rx_byte,
  input  logic [15:0]          temperature,
  input  logic [15:0]          timeout_ticks,
  input  logic                 full,
  output logic                 push,
  output vcfh_pkg::job_t       job
);

  localparam logic [1:0] PS_SYNC = 2'd0;
  localparam logic [1:0] PS_DATA = 2'd1;
  localparam logic [1:0] PS_CSUM = 2'd2;

  logic [1:0]  parse_state, parse_state_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [7:0]  param_low, param_low_next;
  logic [7:0]  param_high, param_high_next;
  logic [15:0] current_frequency, current_frequency_next;
  logic [15:0] configured_power, configured_power_next;
  logic        pit_mode, pit_mode_next;
  logic [15:0] timeout_counter, timeout_counter_next;
  logic [1:0]  status;
  logic [1:0]  kind;
  logic        reboot;

  assign req_ready = !full;
  assign push      = req_valid && !full;

  // Next-state logic for one accepted transaction.
  always_comb begin
    parse_state_next       = parse_state;
    byte_index_next        = byte_index;
    running_sum_next       = running_sum;
    command_byte_next      = command_byte;
    param_low_next         = param_low;
    param_high_next        = param_high;
    current_frequency_next = current_frequency;
    configured_power_next  = configured_power;
    pit_mode_next          = pit_mode;
    timeout_counter_next   = timeout_counter;
    status                 = vcfh_pkg::ST_LISTEN;
    kind                   = vcfh_pkg::RPL_NONE;
    reboot                 = 1'b0;

    if (req_type) begin
      // Timer tick: count down, and on expiry drop back to hunting.
      if (timeout_counter <= 16'd1) begin
        parse_state_next     = PS_SYNC;
        byte_index_next      = '0;
        running_sum_next     = '0;
        timeout_counter_next = timeout_ticks;
        status               = vcfh_pkg::ST_TIMEOUT;
      end else begin
        timeout_counter_next = timeout_counter - 16'd1;
      end
    end else begin
      unique case (parse_state)
        PS_DATA: begin
          if (byte_index == 4'd1) begin
            command_byte_next = rx_byte;
          end else if (byte_index == 4'd2) begin
            param_low_next = rx_byte;
          end else if (byte_index == 4'd3) begin
            param_high_next = rx_byte;
          end
          running_sum_next = running_sum + rx_byte;
          if (byte_index >= 4'(vcfh_pkg::LAST_DATA)) begin
            parse_state_next = PS_CSUM;
          end
          byte_index_next = byte_index + 4'd1;
        end
        PS_CSUM: begin
          if (rx_byte == running_sum) begin
            case (command_byte)
              vcfh_pkg::CMD_FREQ:    current_frequency_next = {param_high, param_low};
              vcfh_pkg::CMD_POWER:   configured_power_next = {param_high, param_low};
              vcfh_pkg::CMD_PIT:     pit_mode_next = (param_low == 8'd0);
              vcfh_pkg::CMD_REBOOT:  reboot = (param_low == vcfh_pkg::ARG_S) &&
                                              (param_high == vcfh_pkg::ARG_T);
              vcfh_pkg::CMD_RANGE:   kind = vcfh_pkg::RPL_RANGE;
              vcfh_pkg::CMD_VERSION: kind = vcfh_pkg::RPL_VERSION;
              vcfh_pkg::CMD_STATUS:  kind = vcfh_pkg::RPL_STATUS;
              default: ;
            endcase
            timeout_counter_next = timeout_ticks;
            status               = vcfh_pkg::ST_VALID;
          end else begin
            status = vcfh_pkg::ST_ERROR;
          end
          parse_state_next = PS_SYNC;
          byte_index_next  = '0;
        end
        default: begin
          // Hunting for a header; the unused state code behaves the same.
          if (rx_byte == vcfh_pkg::HDR_BYTE) begin
            parse_state_next = PS_DATA;
            byte_index_next  = 4'd1;
            running_sum_next = '0;
          end else begin
            parse_state_next = PS_SYNC;
            byte_index_next  = '0;
            status           = vcfh_pkg::ST_ERROR;
          end
        end
      endcase
    end
  end

  // Job descriptor reflects the state after this transaction.
  always_comb begin
    job.status      = status;
    job.kind        = kind;
    job.command     = command_byte;
    job.frequency   = current_frequency_next;
    job.power       = configured_power_next;
    job.pit_mode    = pit_mode_next;
    job.reboot      = reboot;
    job.temperature = temperature;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state       <= PS_SYNC;
      byte_index        <= '0;
      running_sum       <= '0;
      command_byte      <= '0;
      param_low         <= '0;
      param_high        <= '0;
      current_frequency <= '0;
      configured_power  <= '0;
      pit_mode          <= 1'b0;
      timeout_counter   <= vcfh_pkg::RST_INIT_TIMEOUT;
    end else if (push) begin
      parse_state       <= parse_state_next;
      byte_index        <= byte_index_next;
      running_sum       <= running_sum_next;
      command_byte      <= command_byte_next;
      param_low         <= param_low_next;
      param_high        <= param_high_next;
      current_frequency <= current_frequency_next;
      configured_power  <= configured_power_next;
      pit_mode          <= pit_mode_next;
      timeout_counter   <= timeout_counter_next;
    end
  end

endmodule

// ===== design/vcfh_queue.sv =====
// Short job queue that decouples the parser from the reply emitter.
module vcfh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vcfh_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output vcfh_pkg::job_t head_job
);

  vcfh_pkg::job_t                  entries [vcfh_pkg::QUEUE_DEPTH];
  logic [vcfh_pkg::QPTR_W-1:0]     wr_ptr;
  logic [vcfh_pkg::QPTR_W-1:0]     rd_ptr;
  logic [vcfh_pkg::QCNT_W-1:0]     count;

  assign full       = (count == vcfh_pkg::QCNT_W'(vcfh_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == vcfh_pkg::QPTR_W'(vcfh_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == vcfh_pkg::QPTR_W'(vcfh_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== design/vcfh_back.sv =====
// Reply emitter: turns each job into one status result or a serialized reply.
module vcfh_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  vcfh_pkg::job_t head_job,
  output logic           pop,
  input  vcfh_pkg::cfg_t cfg,
  vcfh_rsp_if.source     rsp
);

  logic [3:0] pos;
  logic [7:0] sum_acc;
  logic       slot_free;
  logic       load;
  logic       is_reply;
  logic       is_last;
  logic [7:0] payload;
  logic [7:0] tx_byte_c;

  // Payload byte of a reply at a given position, before checksum and pad.
  function automatic logic [7:0] reply_payload(input vcfh_pkg::job_t j,
                                               input vcfh_pkg::cfg_t c,
                                               input logic [3:0] p);
    logic [7:0] b;
    b = 8'd0;
    if (p == 4'd0) begin
      b = vcfh_pkg::HDR_BYTE;
    end else if (p == 4'd1) begin
      b = j.command;
    end else begin
      case (j.kind)
        vcfh_pkg::RPL_RANGE: begin
          case (p)
            4'd2:    b = c.min_frequency[7:0];
            4'd3:    b = c.min_frequency[15:8];
            4'd4:    b = c.max_frequency[7:0];
            4'd5:    b = c.max_frequency[15:8];
            4'd6:    b = c.power_cap[7:0];
            4'd7:    b = c.power_cap[15:8];
            default: b = 8'd0;
          endcase
        end
        vcfh_pkg::RPL_VERSION: begin
          case (p)
            4'd2:    b = j.frequency[7:0];
            4'd3:    b = j.frequency[15:8];
            4'd4:    b = j.power[7:0];
            4'd5:    b = j.power[15:8];
            4'd7:    b = {7'd0, j.pit_mode};
            4'd8:    b = j.power[7:0];
            4'd9:    b = j.power[15:8];
            default: b = 8'd0;
          endcase
        end
        vcfh_pkg::RPL_STATUS: begin
          case (p)
            4'd6:    b = j.temperature[7:0];
            4'd7:    b = j.temperature[15:8];
            default: b = 8'd0;
          endcase
        end
        default: b = 8'd0;
      endcase
    end
    return b;
  endfunction

  assign slot_free = !rsp.valid || rsp.ready;
  assign load      = head_valid && slot_free;
  assign is_reply  = (head_job.kind != vcfh_pkg::RPL_NONE);
  assign is_last   = !is_reply || (pos == 4'(vcfh_pkg::PAD_POS));
  assign pop       = load && is_last;
  assign payload   = reply_payload(head_job, cfg, pos);

  // Checksum slot carries the accumulated sum, the final slot is zero pad.
  always_comb begin
    if (!is_reply) begin
      tx_byte_c = 8'd0;
    end else if (pos == 4'(vcfh_pkg::CSUM_POS)) begin
      tx_byte_c = sum_acc;
    end else if (pos == 4'(vcfh_pkg::PAD_POS)) begin
      tx_byte_c = 8'd0;
    end else begin
      tx_byte_c = payload;
    end
  end

  // Control: output valid, byte position and running reply checksum.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
      pos       <= '0;
      sum_acc   <= '0;
    end else begin
      if (slot_free) begin
        rsp.valid <= head_valid;
      end
      if (load) begin
        if (is_last) begin
          pos <= '0;
        end else begin
          pos <= pos + 4'd1;
        end
        if (pos == 4'd0) begin
          sum_acc <= '0;
        end else if (pos <= 4'(vcfh_pkg::LAST_DATA)) begin
          sum_acc <= sum_acc + payload;
        end
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status         <= head_job.status;
      rsp.tx_valid       <= is_reply;
      rsp.tx_byte        <= tx_byte_c;
      rsp.last           <= is_last;
      rsp.frequency_out  <= head_job.frequency;
      rsp.power_setting  <= head_job.power;
      rsp.pit_mode_out   <= head_job.pit_mode;
      rsp.drive_power    <= head_job.pit_mode ? cfg.race_power : head_job.power;
      rsp.reboot_request <= head_job.reboot;
    end
  end

endmodule

// ===== design/vtx_control_frame_handler_unit.sv =====
// Top level of the control frame handler: configuration, parser, queue, emitter.
//
// Usage:
//   req_ch carries one transaction per received serial byte (req_type 0) or
//   per timer tick (req_type 1), with the current temperature alongside.
//   rsp_ch returns the results of each transaction in order: a single result
//   with last set, or for the r, v and s commands a 16-byte reply, one byte
//   per result, the final one with last set.
//   Configuration is written through cfg_we, cfg_index and cfg_data while the
//   block is idle; each write takes effect at the next edge.
// Timing: the first result of a transaction passes through the job queue and
//   the output register before it is offered. The block takes one transaction
//   per cycle while each causes a single result and the receiver keeps up; a
//   reply holds the output for its 16 results, during which the two-entry job
//   queue fills and req_ch.ready drops.
// Reset (rst, synchronous) returns the parser to header search, clears the
//   queue and output, and loads the timeout counter with its initial window.
// When the receiver stalls, the output holds its result, the parser keeps
//   accepting until the job queue is full, and then req_ch.ready goes low.
module vtx_control_frame_handler_unit (
  input  logic                           clk,
  input  logic                           rst,
  vcfh_req_if.sink                       req_ch,
  vcfh_rsp_if.source                     rsp_ch,
  input  logic                           cfg_we,
  input  logic [vcfh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  vcfh_pkg::cfg_t cfg;
  vcfh_pkg::job_t push_job;
  vcfh_pkg::job_t head_job;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;

  // Configuration registers. The initial timeout window only matters at
  // reset, where the counter takes its reset value directly, so writes to
  // it have no lasting effect and are not stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_frequency <= vcfh_pkg::RST_MIN_FREQ;
      cfg.max_frequency <= vcfh_pkg::RST_MAX_FREQ;
      cfg.power_cap     <= vcfh_pkg::RST_POWER_CAP;
      cfg.race_power    <= vcfh_pkg::RST_RACE_POWER;
      cfg.timeout_ticks <= vcfh_pkg::RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        vcfh_pkg::REG_MIN_FREQ:     cfg.min_frequency <= cfg_data;
        vcfh_pkg::REG_MAX_FREQ:     cfg.max_frequency <= cfg_data;
        vcfh_pkg::REG_POWER_CAP:    cfg.power_cap     <= cfg_data;
        vcfh_pkg::REG_RACE_POWER:   cfg.race_power    <= cfg_data;
        vcfh_pkg::REG_TIMEOUT:      cfg.timeout_ticks <= cfg_data;
        vcfh_pkg::REG_INIT_TIMEOUT: ;
        default: ;
      endcase
    end
  end

  // Parser front end.
  vcfh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_type      (req_ch.req_type),
    .rx_byte       (req_ch.rx_byte),
    .temperature   (req_ch.temperature),
    .timeout_ticks (cfg.timeout_ticks),
    .full          (full),
    .push          (push),
    .job           (push_job)
  );

  // Job queue.
  vcfh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Reply emitter.
  vcfh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .cfg        (cfg),
    .rsp        (rsp_ch)
  );

endmodule

// ===== design/vcfh_checker.sv =====
// Port-level checks of the control frame handler, bound to the top level.
module vcfh_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic        tx_valid,
  input logic [7:0]  tx_byte,
  input logic        last,
  input logic [15:0] power_setting,
  input logic        pit_mode_out,
  input logic [15:0] drive_power,
  input logic        reboot_request
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response valid dropped while stalled");

  // Reply bytes only come from a frame that passed its checksum.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && tx_valid |-> status == vcfh_pkg::ST_VALID)
    else $error("reply byte with non-valid status");

  // A result without a reply byte is a lone result with a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !tx_valid |-> last && tx_byte == 8'd0)
    else $error("non-reply result not last or byte nonzero");

  // A reboot request is never part of a reply.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && reboot_request |-> !tx_valid && status == vcfh_pkg::ST_VALID)
    else $error("reboot request on a reply or invalid frame");

  // Outside pit mode the radio is driven at the set power.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !pit_mode_out |-> drive_power == power_setting)
    else $error("drive power differs from setting outside pit mode");

endmodule

bind vtx_control_frame_handler_unit vcfh_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp_ch.valid),
  .rsp_ready      (rsp_ch.ready),
  .status         (rsp_ch.status),
  .tx_valid       (rsp_ch.tx_valid),
  .tx_byte        (rsp_ch.tx_byte),
  .last           (rsp_ch.last),
  .power_setting  (rsp_ch.power_setting),
  .pit_mode_out   (rsp_ch.pit_mode_out),
  .drive_power    (rsp_ch.drive_power),
  .reboot_request (rsp_ch.reboot_request)
);
